[sv/pfi_pkg.sv]
// pfi_pkg: shared constants, command codes and saturation helpers
// for the particle force integrator; no dependencies
`timescale 1ns / 1ps

package pfi_pkg;

  // fixed point layout
  localparam int FRAC_BITS = 16;
  localparam int GAIN_BITS = 16;

  // command codes carried in tuser
  localparam logic [1:0] CMD_PLAIN   = 2'd0;
  localparam logic [1:0] CMD_REPEL   = 2'd1;
  localparam logic [1:0] CMD_ATTRACT = 2'd2;
  localparam logic [1:0] CMD_LOAD    = 2'd3;

  // register indexes (byte address / 4)
  localparam logic [2:0] REG_DAMPING = 3'd0;
  localparam logic [2:0] REG_WALL_W  = 3'd1;
  localparam logic [2:0] REG_WALL_H  = 3'd2;
  localparam logic [2:0] REG_BOUNCE  = 3'd3;
  localparam logic [2:0] REG_BNC_EN  = 3'd4;

  // register reset values
  localparam logic [15:0] DAMPING_RST = 16'd66;
  localparam logic [30:0] WALL_W_RST  = 31'd67108864;
  localparam logic [30:0] WALL_H_RST  = 31'd50331648;
  localparam logic [15:0] BOUNCE_RST  = 16'd16384;

  // clamp a 34-bit signed value to the 32-bit signed range
  function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > 34'sh0_7FFF_FFFF) r = 32'sh7FFF_FFFF;
    else if (v < -34'sh0_8000_0000) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  // saturating a + b
  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [33:0] s;
    s = {{2{a[31]}}, a} + {{2{b[31]}}, b};
    return sat34(s);
  endfunction

  // saturating a - b
  function automatic logic signed [31:0] sat_sub(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [33:0] s;
    s = {{2{a[31]}}, a} - {{2{b[31]}}, b};
    return sat34(s);
  endfunction

endpackage

[sv/pfi_mul.sv]
// pfi_mul: bit-serial shift-add multiplier, 32 x 32 unsigned, one
// multiplier bit per cycle; depends on nothing else
`timescale 1ns / 1ps

module pfi_mul (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic        done,
  output logic [63:0] prod
);

  logic [31:0] a_r;
  logic [31:0] hi;
  logic [31:0] lo;
  logic [4:0]  cnt;
  logic        busy;
  logic [32:0] sum;

  // add multiplicand when the low multiplier bit is set
  assign sum  = {1'b0, hi} + (lo[0] ? {1'b0, a_r} : 33'd0);
  assign prod = {hi, lo};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath shift register
  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
      hi  <= '0;
      lo  <= b;
    end else if (busy) begin
      hi <= sum[32:1];
      lo <= {sum[0], lo[31:1]};
    end
  end

endmodule

[sv/pfi_div.sv]
// pfi_div: restoring divider, 64 by 32 bits with a 32-bit quotient,
// one quotient bit per cycle; needs dividend[63:32] < divisor
`timescale 1ns / 1ps

module pfi_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quot
);

  logic [31:0] d_r;
  logic [31:0] rem;
  logic [31:0] q;
  logic [4:0]  cnt;
  logic        busy;
  logic [32:0] trial;
  logic        fits;

  // shift in the next dividend bit and try a subtract
  assign trial = {rem, q[31]};
  assign fits  = trial >= {1'b0, d_r};
  assign quot  = q;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      d_r <= divisor;
      rem <= dividend[63:32];
      q   <= dividend[31:0];
    end else if (busy) begin
      rem <= fits ? 32'(trial - {1'b0, d_r}) : trial[31:0];
      q   <= {q[30:0], fits};
    end
  end

endmodule

[sv/particle_force_integrator_unit.sv]
// particle_force_integrator_unit: 2D particle force accumulation and euler step
// depends on pfi_pkg, pfi_mul, pfi_div
// a point force runs square, root, ratio, magnitude, products and quotients on the
// bit-serial multipliers, divider and root; it ends after the radius box test when
// outside the box and after the root at zero distance or past the radius; a closing
// beat adds damping, velocity, position and wall steps, and a bounce step on a wall
// hit with bounce damping enabled, plus any output stall; one item at a time
// reset clears position, velocity, force and the registers to their defaults
`timescale 1ns / 1ps

module particle_force_integrator_unit
  import pfi_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  // input stream
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [191:0] s_tdata,  // src_x, src_y, radius, strength, load_vel_x, load_vel_y
  input  logic [1:0]   s_tuser,  // cmd
  input  logic         s_tlast,
  // output stream
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [127:0] m_tdata,  // pos_x, pos_y, vel_x, vel_y
  output logic [0:0]   m_tuser,  // collided
  // configuration
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_DISP = 5'd1;
  localparam logic [4:0] ST_SQ   = 5'd2;
  localparam logic [4:0] ST_ROOT = 5'd3;
  localparam logic [4:0] ST_LCHK = 5'd4;
  localparam logic [4:0] ST_PCT  = 5'd5;
  localparam logic [4:0] ST_MAG  = 5'd6;
  localparam logic [4:0] ST_FMUL = 5'd7;
  localparam logic [4:0] ST_FDIV = 5'd8;
  localparam logic [4:0] ST_CHK  = 5'd9;
  localparam logic [4:0] ST_DAMP = 5'd10;
  localparam logic [4:0] ST_VEL  = 5'd11;
  localparam logic [4:0] ST_POS  = 5'd12;
  localparam logic [4:0] ST_WALL = 5'd13;
  localparam logic [4:0] ST_BNC  = 5'd14;
  localparam logic [4:0] ST_EMIT = 5'd15;

  // configuration registers
  logic [15:0] damping_gain;
  logic [30:0] wall_width;
  logic [30:0] wall_height;
  logic [15:0] bounce_gain;
  logic        bounce_damp_enable;

  // particle state
  logic signed [31:0] pos_x, pos_y, vel_x, vel_y, frc_x, frc_y;

  // latched item
  logic [1:0]         cmd;
  logic signed [31:0] src_x, src_y, lvel_x, lvel_y;
  logic [30:0]        radius, strength;
  logic               last;

  // point force working registers
  logic [30:0] adx, ady;
  logic        neg_x, neg_y;
  logic [63:0] sq_n, sq_res, sq_bit;
  logic [4:0]  sq_cnt;
  logic [31:0] len;
  logic        hit;

  // serial units
  logic        mul_start, div_start;
  logic [31:0] mul_a0, mul_b0, mul_a1, mul_b1;
  logic [63:0] div_n0, div_n1;
  logic [31:0] div_d;
  logic        mul_done0, mul_done1, div_done0, div_done1;
  logic [63:0] prod0, prod1;
  logic [31:0] quot0, quot1;

  logic [4:0] state;

  pfi_mul u_mul0 (.clk, .rst, .start(mul_start), .a(mul_a0), .b(mul_b0),
                  .done(mul_done0), .prod(prod0));
  pfi_mul u_mul1 (.clk, .rst, .start(mul_start), .a(mul_a1), .b(mul_b1),
                  .done(mul_done1), .prod(prod1));
  pfi_div u_div0 (.clk, .rst, .start(div_start), .dividend(div_n0), .divisor(div_d),
                  .done(div_done0), .quot(quot0));
  pfi_div u_div1 (.clk, .rst, .start(div_start), .dividend(div_n1), .divisor(div_d),
                  .done(div_done1), .quot(quot1));

  // combinational helpers
  logic signed [32:0] dx, dy;
  logic [32:0]        adx_w, ady_w;
  logic [63:0]        sq_try;
  logic signed [31:0] damp_x, damp_y, fx_s, fy_s;
  logic signed [31:0] wpos_x, wpos_y, wvel_x, wvel_y;
  logic               whit;
  logic [31:0]        mag;

  assign dx    = {pos_x[31], pos_x} - {src_x[31], src_x};
  assign dy    = {pos_y[31], pos_y} - {src_y[31], src_y};
  assign adx_w = dx[32] ? 33'(-dx) : 33'(dx);
  assign ady_w = dy[32] ? 33'(-dy) : 33'(dy);
  assign sq_try = sq_res + sq_bit;
  assign mag    = prod0[FRAC_BITS +: 32];

  // damping term and signed point force
  assign damp_x = vel_x[31] ? -$signed(prod0[GAIN_BITS +: 32]) : $signed(prod0[GAIN_BITS +: 32]);
  assign damp_y = vel_y[31] ? -$signed(prod1[GAIN_BITS +: 32]) : $signed(prod1[GAIN_BITS +: 32]);
  assign fx_s   = neg_x ? -$signed(quot0) : $signed(quot0);
  assign fy_s   = neg_y ? -$signed(quot1) : $signed(quot1);

  // wall clamp
  always_comb begin
    wpos_x = pos_x;
    wpos_y = pos_y;
    wvel_x = vel_x;
    wvel_y = vel_y;
    whit   = 1'b0;
    if ($signed({pos_x[31], pos_x}) > $signed({2'b00, wall_width})) begin
      wpos_x = $signed({1'b0, wall_width});
      wvel_x = sat_sub(32'sd0, vel_x);
      whit   = 1'b1;
    end else if (pos_x[31]) begin
      wpos_x = '0;
      wvel_x = sat_sub(32'sd0, vel_x);
      whit   = 1'b1;
    end
    if ($signed({pos_y[31], pos_y}) > $signed({2'b00, wall_height})) begin
      wpos_y = $signed({1'b0, wall_height});
      wvel_y = sat_sub(32'sd0, vel_y);
      whit   = 1'b1;
    end else if (pos_y[31]) begin
      wpos_y = '0;
      wvel_y = sat_sub(32'sd0, vel_y);
      whit   = 1'b1;
    end
  end

  assign s_tready = (state == ST_IDLE);
  assign pready   = 1'b1;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      damping_gain       <= DAMPING_RST;
      wall_width         <= WALL_W_RST;
      wall_height        <= WALL_H_RST;
      bounce_gain        <= BOUNCE_RST;
      bounce_damp_enable <= 1'b1;
    end else if (psel && penable && pwrite) begin
      case (paddr[4:2])
        REG_DAMPING: damping_gain       <= pwdata[15:0];
        REG_WALL_W:  wall_width         <= pwdata[30:0];
        REG_WALL_H:  wall_height        <= pwdata[30:0];
        REG_BOUNCE:  bounce_gain        <= pwdata[15:0];
        REG_BNC_EN:  bounce_damp_enable <= pwdata[0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (paddr[4:2])
      REG_DAMPING: prdata = {16'd0, damping_gain};
      REG_WALL_W:  prdata = {1'b0, wall_width};
      REG_WALL_H:  prdata = {1'b0, wall_height};
      REG_BOUNCE:  prdata = {16'd0, bounce_gain};
      REG_BNC_EN:  prdata = {31'd0, bounce_damp_enable};
      default:     prdata = '0;
    endcase
  end

  // sequencer and particle state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      pos_x     <= '0;
      pos_y     <= '0;
      vel_x     <= '0;
      vel_y     <= '0;
      frc_x     <= '0;
      frc_y     <= '0;
      m_tvalid  <= 1'b0;
      mul_start <= 1'b0;
      div_start <= 1'b0;
      hit       <= 1'b0;
    end else begin
      mul_start <= 1'b0;
      div_start <= 1'b0;
      // the emit step handles its own output handshake
      if (m_tvalid && m_tready && state != ST_EMIT) m_tvalid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            cmd      <= s_tuser;
            src_x    <= s_tdata[31:0];
            src_y    <= s_tdata[63:32];
            radius   <= s_tdata[94:64];
            strength <= s_tdata[125:95];
            lvel_x   <= s_tdata[157:126];
            lvel_y   <= s_tdata[189:158];
            last     <= s_tlast;
            state    <= ST_DISP;
          end
        end
        ST_DISP: begin
          case (cmd)
            CMD_PLAIN: begin
              frc_x <= sat_add(frc_x, src_x);
              frc_y <= sat_add(frc_y, src_y);
              state <= ST_CHK;
            end
            CMD_LOAD: begin
              pos_x <= src_x;
              pos_y <= src_y;
              vel_x <= lvel_x;
              vel_y <= lvel_y;
              state <= ST_CHK;
            end
            default: begin
              neg_x <= dx[32] ^ (cmd == CMD_ATTRACT);
              neg_y <= dy[32] ^ (cmd == CMD_ATTRACT);
              adx   <= adx_w[30:0];
              ady   <= ady_w[30:0];
              if (radius == '0 || adx_w > {2'b00, radius} || ady_w > {2'b00, radius}) begin
                state <= ST_CHK;
              end else begin
                mul_a0    <= {1'b0, adx_w[30:0]};
                mul_b0    <= {1'b0, adx_w[30:0]};
                mul_a1    <= {1'b0, ady_w[30:0]};
                mul_b1    <= {1'b0, ady_w[30:0]};
                mul_start <= 1'b1;
                state     <= ST_SQ;
              end
            end
          endcase
        end
        // sum of squares
        ST_SQ: begin
          if (mul_done0) begin
            sq_n   <= prod0 + prod1;
            sq_res <= '0;
            sq_bit <= 64'd1 << 62;
            sq_cnt <= '0;
            state  <= ST_ROOT;
          end
        end
        // one root bit per cycle
        ST_ROOT: begin
          if (sq_n >= sq_try) begin
            sq_n   <= sq_n - sq_try;
            sq_res <= (sq_res >> 1) + sq_bit;
          end else begin
            sq_res <= sq_res >> 1;
          end
          sq_bit <= sq_bit >> 2;
          sq_cnt <= sq_cnt + 5'd1;
          if (sq_cnt == 5'd31) state <= ST_LCHK;
        end
        // falloff ratio (radius - len) / radius
        ST_LCHK: begin
          len <= sq_res[31:0];
          if (sq_res == '0 || sq_res > {33'd0, radius}) begin
            state <= ST_CHK;
          end else begin
            div_n0    <= {33'd0, 31'(radius - sq_res[30:0])} << FRAC_BITS;
            div_d     <= {1'b0, radius};
            div_start <= 1'b1;
            state     <= ST_PCT;
          end
        end
        ST_PCT: begin
          if (div_done0) begin
            mul_a0    <= {1'b0, strength};
            mul_b0    <= quot0;
            mul_start <= 1'b1;
            state     <= ST_MAG;
          end
        end
        ST_MAG: begin
          if (mul_done0) begin
            mul_a0    <= {1'b0, adx};
            mul_b0    <= mag;
            mul_a1    <= {1'b0, ady};
            mul_b1    <= mag;
            mul_start <= 1'b1;
            state     <= ST_FMUL;
          end
        end
        ST_FMUL: begin
          if (mul_done0) begin
            div_n0    <= prod0;
            div_n1    <= prod1;
            div_d     <= len;
            div_start <= 1'b1;
            state     <= ST_FDIV;
          end
        end
        ST_FDIV: begin
          if (div_done0) begin
            frc_x <= sat_add(frc_x, fx_s);
            frc_y <= sat_add(frc_y, fy_s);
            state <= ST_CHK;
          end
        end
        // frame close on a last beat: damping products, else back to idle
        ST_CHK: begin
          if (last) begin
            mul_a0    <= vel_x[31] ? 32'(-vel_x) : 32'(vel_x);
            mul_b0    <= {16'd0, damping_gain};
            mul_a1    <= vel_y[31] ? 32'(-vel_y) : 32'(vel_y);
            mul_b1    <= {16'd0, damping_gain};
            mul_start <= 1'b1;
            state     <= ST_DAMP;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_DAMP: begin
          if (mul_done0) begin
            frc_x <= sat_sub(frc_x, damp_x);
            frc_y <= sat_sub(frc_y, damp_y);
            state <= ST_VEL;
          end
        end
        ST_VEL: begin
          vel_x <= sat_add(vel_x, frc_x);
          vel_y <= sat_add(vel_y, frc_y);
          state <= ST_POS;
        end
        ST_POS: begin
          pos_x <= sat_add(pos_x, vel_x);
          pos_y <= sat_add(pos_y, vel_y);
          state <= ST_WALL;
        end
        ST_WALL: begin
          pos_x <= wpos_x;
          pos_y <= wpos_y;
          vel_x <= wvel_x;
          vel_y <= wvel_y;
          hit   <= whit;
          if (whit && bounce_damp_enable) begin
            mul_a0    <= wvel_x[31] ? 32'(-wvel_x) : 32'(wvel_x);
            mul_b0    <= {16'd0, bounce_gain};
            mul_a1    <= wvel_y[31] ? 32'(-wvel_y) : 32'(wvel_y);
            mul_b1    <= {16'd0, bounce_gain};
            mul_start <= 1'b1;
            state     <= ST_BNC;
          end else begin
            state <= ST_EMIT;
          end
        end
        ST_BNC: begin
          if (mul_done0) begin
            vel_x <= damp_x;
            vel_y <= damp_y;
            state <= ST_EMIT;
          end
        end
        // hand the beat to the output register
        ST_EMIT: begin
          if (!m_tvalid || m_tready) begin
            m_tdata  <= {vel_y, vel_x, pos_y, pos_x};
            m_tuser  <= hit;
            m_tvalid <= 1'b1;
            frc_x    <= '0;
            frc_y    <= '0;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // a pending result is never overwritten
  a_emit_hold: assert property (@(posedge clk) disable iff (rst)
    state == ST_EMIT && m_tvalid && !m_tready |=> state == ST_EMIT)
    else $error("emit left while output beat pending");

  // a new result only comes from the emit step
  a_emit_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == ST_EMIT)
    else $error("output beat raised outside emit");

  // the two multipliers always run in lockstep
  a_mul_lock: assert property (@(posedge clk) disable iff (rst)
    mul_done0 == mul_done1)
    else $error("multipliers out of step");

  // the two dividers always run in lockstep
  a_div_lock: assert property (@(posedge clk) disable iff (rst)
    div_done0 == div_done1)
    else $error("dividers out of step");

  // an accepted beat is dispatched next
  a_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> state == ST_DISP && !s_tready)
    else $error("accepted beat not dispatched");

endmodule
